### src/npc_pkg.sv
// Shared types and constants for the nearest palette color search.
package npc_pkg;

  localparam int PALETTE_DEPTH = 16;
  localparam int INDEX_W       = 4;
  localparam int CHAN_W        = 8;
  localparam int COLOR_W       = 3 * CHAN_W;
  localparam int DIST_W        = 18;
  localparam int COUNT_W       = $clog2(PALETTE_DEPTH + 1);
  localparam int CFG_COUNT_W   = 5;
  localparam int PADDR_W       = 3;
  localparam int PDATA_W       = 32;

  localparam logic [PADDR_W-3:0] REG_ENTRY_COUNT = '0;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [INDEX_W-1:0]  entry_index;
    logic [CHAN_W-1:0]   red;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   blue;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0]  best_index;
    logic [COLOR_W-1:0]  best_color;
    logic [DIST_W-1:0]   best_distance_sq;
  } out_item_t;

  // What travels from one cell to the next: the item plus the running best.
  typedef struct packed {
    opcode_t             opcode;
    logic [INDEX_W-1:0]  entry_index;
    logic [CHAN_W-1:0]   red;
    logic [CHAN_W-1:0]   green;
    logic [CHAN_W-1:0]   blue;
    logic [INDEX_W-1:0]  best_index;
    logic [COLOR_W-1:0]  best_color;
    logic [DIST_W-1:0]   best_dist;
  } stage_t;

endpackage

### src/nearest_palette_color_rgb888_core.sv
// Top level of the nearest palette color search: cell chain, result port, register port.
// Items enter a chain of 16 palette cells and move on one cell whenever the chain
// advances, and a query's result leaves the last cell. The chain sustains one item per
// cycle, loads and queries mixed in any order; a load takes effect for every query
// behind it. While a result waits at the output the whole chain holds and no item is
// taken. Palette entries are not cleared by reset: write each searched entry first.
// Register entry_count at address 0 (0 behaves as 1, above 16 as 16).
module nearest_palette_color_rgb888_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  npc_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output npc_pkg::out_item_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [npc_pkg::PADDR_W-1:0] paddr,
  input  logic [npc_pkg::PDATA_W-1:0] pwdata,
  output logic [npc_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import npc_pkg::*;

  logic [CFG_COUNT_W-1:0] entry_count;
  logic [COUNT_W-1:0]     count_eff;
  logic                   advance;
  logic                   stage_valid [PALETTE_DEPTH+1];
  stage_t                 stage       [PALETTE_DEPTH+1];

  // Register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= CFG_COUNT_W'(1);
    end else if (psel && penable && pwrite && pready &&
                 (paddr[PADDR_W-1:2] == REG_ENTRY_COUNT)) begin
      entry_count <= pwdata[CFG_COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1:2] == REG_ENTRY_COUNT) begin
      prdata = PDATA_W'(entry_count);
    end
  end

  always_comb begin
    priority if (entry_count == '0) begin
      count_eff = COUNT_W'(1);
    end else if (32'(entry_count) > PALETTE_DEPTH) begin
      count_eff = COUNT_W'(PALETTE_DEPTH);
    end else begin
      count_eff = COUNT_W'(entry_count);
    end
  end

  // Chain
  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  always_comb begin
    stage_valid[0]        = in_valid;
    stage[0].opcode       = in_data.opcode;
    stage[0].entry_index  = in_data.entry_index;
    stage[0].red          = in_data.red;
    stage[0].green        = in_data.green;
    stage[0].blue         = in_data.blue;
    stage[0].best_index   = '0;
    stage[0].best_color   = '0;
    stage[0].best_dist    = '0;
  end

  for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
    npc_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (advance),
      .cell_index (INDEX_W'(i)),
      .count      (count_eff),
      .in_valid   (stage_valid[i]),
      .in_stage   (stage[i]),
      .out_valid  (stage_valid[i+1]),
      .out_stage  (stage[i+1])
    );
  end

  // Loads drop off the end of the chain; only queries become results.
  assign out_valid = stage_valid[PALETTE_DEPTH] &&
                     (stage[PALETTE_DEPTH].opcode == OP_QUERY);

  always_comb begin
    out_data.best_index       = stage[PALETTE_DEPTH].best_index;
    out_data.best_color       = stage[PALETTE_DEPTH].best_color;
    out_data.best_distance_sq = stage[PALETTE_DEPTH].best_dist;
  end

  // Checks
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("item taken while a result is stalled");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (COUNT_W'(out_data.best_index) < count_eff))
    else $error("result index beyond searched entries");

  a_dist_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.best_distance_sq <= DIST_W'(195075)))
    else $error("squared distance out of range");

  a_chain_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> (stage_valid[PALETTE_DEPTH] == $past(stage_valid[PALETTE_DEPTH])))
    else $error("chain moved during a stall");

endmodule

### src/npc_cell.sv
// One palette cell: holds one entry and updates the running best of a passing query.
module npc_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [npc_pkg::INDEX_W-1:0] cell_index,
  input  logic [npc_pkg::COUNT_W-1:0] count,
  input  logic                       in_valid,
  input  npc_pkg::stage_t            in_stage,
  output logic                       out_valid,
  output npc_pkg::stage_t            out_stage
);
  import npc_pkg::*;

  logic [COLOR_W-1:0]   entry;
  logic [CHAN_W-1:0]    dr, dg, db;
  logic [2*CHAN_W-1:0]  sr, sg, sb;
  logic [DIST_W-1:0]    cand_dist;
  logic                 take;
  stage_t               stage_next;

  always_comb begin
    dr = (entry[23:16] >= in_stage.red) ? entry[23:16] - in_stage.red
                                        : in_stage.red - entry[23:16];
    dg = (entry[15:8] >= in_stage.green) ? entry[15:8] - in_stage.green
                                         : in_stage.green - entry[15:8];
    db = (entry[7:0] >= in_stage.blue) ? entry[7:0] - in_stage.blue
                                       : in_stage.blue - entry[7:0];
    sr = dr * dr;
    sg = dg * dg;
    sb = db * db;
    cand_dist = DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
  end

  // Cell zero seeds the best; later cells win only on a strictly smaller distance.
  always_comb begin
    take = (in_stage.opcode == OP_QUERY) &&
           ((cell_index == '0) ||
            ((COUNT_W'(cell_index) < count) && (cand_dist < in_stage.best_dist)));
    stage_next = in_stage;
    if (take) begin
      stage_next.best_index = cell_index;
      stage_next.best_color = entry;
      stage_next.best_dist  = cand_dist;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid && (in_stage.opcode == OP_LOAD) &&
        (in_stage.entry_index == cell_index)) begin
      entry <= {in_stage.red, in_stage.green, in_stage.blue};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_stage <= stage_next;
    end
  end

endmodule

### test/tb_top.sv
// Self-checking bench for the nearest palette color search: random loads and queries, checked.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import npc_pkg::*;

  localparam int CHAIN_LAT     = 16;
  localparam int SETTLE_CYCLES = 2 * CHAIN_LAT + 8;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 118;

  localparam logic [PADDR_W-1:0] ADDR_ENTRY_COUNT = {REG_ENTRY_COUNT, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED    = {1'b1, 2'b00};

  // Mirror of the palette and the count register; holds the expected results in order.
  class palette_scoreboard;
    logic [COLOR_W-1:0]     palette [PALETTE_DEPTH];
    logic [CFG_COUNT_W-1:0] count;
    out_item_t              nearest_q [$];
    int                     errors;

    function new();
      foreach (palette[i]) palette[i] = '0;
      count  = CFG_COUNT_W'(1);
      errors = 0;
    endfunction

    function void set_count(logic [CFG_COUNT_W-1:0] c);
      count = c;
    endfunction

    function void note_item(in_item_t it);
      int        span;
      int        best_i;
      int        best_d;
      int        dr;
      int        dg;
      int        db;
      out_item_t res;
      if (it.opcode == OP_LOAD) begin
        palette[it.entry_index] = {it.red, it.green, it.blue};
        return;
      end
      span = (count == 0) ? 1 : ((count > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(count));
      best_i = 0;
      best_d = 32'h7fffffff;
      // strict less-than keeps the lowest index on ties
      for (int i = 0; i < span; i++) begin
        dr = int'(palette[i][COLOR_W-1 -: CHAN_W]) - int'(it.red);
        dg = int'(palette[i][2*CHAN_W-1 -: CHAN_W]) - int'(it.green);
        db = int'(palette[i][CHAN_W-1:0]) - int'(it.blue);
        if (dr * dr + dg * dg + db * db < best_d) begin
          best_d = dr * dr + dg * dg + db * db;
          best_i = i;
        end
      end
      res.best_index       = best_i[INDEX_W-1:0];
      res.best_color       = palette[best_i];
      res.best_distance_sq = best_d[DIST_W-1:0];
      nearest_q.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      if (nearest_q.size() == 0) begin
        $error("result with no query pending: index %0d color %06h dist %0d",
               got.best_index, got.best_color, got.best_distance_sq);
        errors++;
        return;
      end
      exp = nearest_q.pop_front();
      if (got.best_index !== exp.best_index) begin
        $error("best_index: expected %0d, got %0d", exp.best_index, got.best_index);
        errors++;
      end
      if (got.best_color !== exp.best_color) begin
        $error("best_color: expected %06h, got %06h", exp.best_color, got.best_color);
        errors++;
      end
      if (got.best_distance_sq !== exp.best_distance_sq) begin
        $error("best_distance_sq: expected %0d, got %0d",
               exp.best_distance_sq, got.best_distance_sq);
        errors++;
      end
    endfunction

    function int pending();
      return nearest_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  int in_idle_pct   = 0;
  int out_stall_pct = 0;

  palette_scoreboard sb = new();

  nearest_palette_color_rgb888_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // receiver: random back-pressure per cycle
  initial begin
    forever begin
      @(negedge clk);
      out_ready <= (int'($urandom_range(99)) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  function automatic in_item_t mk_item(opcode_t op, logic [INDEX_W-1:0] idx,
                                       logic [COLOR_W-1:0] c);
    in_item_t it;
    it.opcode      = op;
    it.entry_index = idx;
    it.red         = c[COLOR_W-1 -: CHAN_W];
    it.green       = c[2*CHAN_W-1 -: CHAN_W];
    it.blue        = c[CHAN_W-1:0];
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic push_item(in_item_t it);
    int gap;
    gap = 0;
    while (int'($urandom_range(99)) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_item(it);
    @(negedge clk);
  endtask

  task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_ENTRY_COUNT) sb.set_count(data[CFG_COUNT_W-1:0]);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_entry_count(logic [CFG_COUNT_W-1:0] c);
    logic [PDATA_W-1:0] data;
    data = $urandom();
    data[CFG_COUNT_W-1:0] = c;
    apb_write(ADDR_ENTRY_COUNT, data);
  endtask

  // Drain all pending results, then let loads still in the chain run out.
  task automatic wait_idle();
    int n;
    n = 0;
    in_valid <= 1'b0;
    while (sb.pending() != 0 && n < DRAIN_LIMIT) begin
      @(negedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [COLOR_W-1:0]     seed_colors [PALETTE_DEPTH];
    logic [COLOR_W-1:0]     col;
    logic [CFG_COUNT_W-1:0] cnt;
    in_item_t               it;
    int                     sel;
    int                     ch;

    seed_colors = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00,
                    24'h0000FF, 24'h808080, 24'hFF0000, 24'h123456,
                    24'hA5A5A5, 24'h5A5A5A, 24'h00FFFF, 24'hFF00FF,
                    24'hFFFF00, 24'h010101, 24'hFEFEFE, 24'h7F7F7F};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    // directed: fill every slot first so no query ever reads an unwritten entry
    for (int i = 0; i < PALETTE_DEPTH; i++)
      push_item(mk_item(OP_LOAD, i[INDEX_W-1:0], seed_colors[i]));
    // reset count searches slot 0 only; white against black is the max distance
    push_item(mk_item(OP_QUERY, 4'hF, 24'hFFFFFF));
    wait_idle();

    set_entry_count(5'd16);
    push_item(mk_item(OP_QUERY, 4'h0, 24'hFF0000));  // tie between two slots
    push_item(mk_item(OP_QUERY, 4'h5, 24'hFFFFFF));
    push_item(mk_item(OP_QUERY, 4'hA, 24'h010203));
    push_item(mk_item(OP_QUERY, 4'h3, 24'h7F7F80));
    wait_idle();

    // zero count acts as one; a write to an unmapped address changes nothing
    set_entry_count(5'd0);
    push_item(mk_item(OP_QUERY, 4'h1, 24'hFFFFFF));
    wait_idle();
    apb_write(ADDR_UNMAPPED, 32'hFFFF_FFF0);
    push_item(mk_item(OP_QUERY, 4'h2, 24'hFEFEFE));
    wait_idle();

    // oversize count saturates; a load right before a query is seen by it
    set_entry_count(5'd31);
    push_item(mk_item(OP_QUERY, 4'h7, 24'h7F7F7F));
    push_item(mk_item(OP_LOAD, 4'h0, 24'h7F7F7F));
    push_item(mk_item(OP_QUERY, 4'h8, 24'h7F7F7F));
    wait_idle();

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 85; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 85; end
        default: begin in_idle_pct = 30; out_stall_pct = 30; end
      endcase
      case (phase)
        0: cnt = 5'd16;
        1: cnt = 5'd1;
        2: cnt = CFG_COUNT_W'($urandom_range(15, 2));
        3: cnt = 5'd31;
        4: cnt = 5'd0;
        5: cnt = CFG_COUNT_W'($urandom_range(31, 1));
        6: cnt = 5'd16;
        default: cnt = CFG_COUNT_W'($urandom_range(31, 17));
      endcase
      set_entry_count(cnt);
      if ($urandom_range(1)) apb_write(ADDR_UNMAPPED, $urandom());

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sel = $urandom_range(99);
        if ($urandom_range(99) < 35) begin
          if (sel < 70) col = COLOR_W'($urandom());
          else if (sel < 85)
            col = sb.palette[INDEX_W'($urandom_range(PALETTE_DEPTH - 1))];
          else
            for (int k = 0; k < 3; k++)
              col[CHAN_W*k +: CHAN_W] = $urandom_range(1) ? 8'hFF : 8'h00;
          it = mk_item(OP_LOAD, INDEX_W'($urandom_range(PALETTE_DEPTH - 1)), col);
        end else begin
          if (sel < 40) begin
            col = COLOR_W'($urandom());
          end else if (sel < 90) begin
            col = sb.palette[INDEX_W'($urandom_range(PALETTE_DEPTH - 1))];
            // mostly near a palette color, sometimes exactly on it
            if (sel < 75)
              for (int k = 0; k < 3; k++) begin
                ch = int'(col[CHAN_W*k +: CHAN_W]) + int'($urandom_range(16)) - 8;
                if (ch < 0) ch = 0;
                if (ch > 255) ch = 255;
                col[CHAN_W*k +: CHAN_W] = ch[CHAN_W-1:0];
              end
          end else begin
            for (int k = 0; k < 3; k++)
              col[CHAN_W*k +: CHAN_W] = $urandom_range(1) ? 8'hFF : 8'h00;
          end
          it = mk_item(OP_QUERY, INDEX_W'($urandom_range(PALETTE_DEPTH - 1)), col);
        end
        push_item(it);
      end
      wait_idle();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
src/npc_pkg.sv
src/npc_cell.sv
src/nearest_palette_color_rgb888_core.sv
test/tb_top.sv
